>>> rtl/efc_pkg.sv
// Shared types and constants of the elevator floor controller.
`default_nettype none

package efc_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DWELL   = 3'd1,
    PH_OPENING = 3'd2,
    PH_CLOSING = 3'd3,
    PH_MOVING  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    REG_CLOSE = 3'd0,
    REG_MOVE  = 3'd1,
    REG_OPEN  = 3'd2,
    REG_DWELL = 3'd3,
    REG_WAIT  = 3'd4,
    REG_LIGHT = 3'd5
  } cfg_reg_e;

  localparam int unsigned TickW    = 16;
  localparam int unsigned BlinkW   = 10;
  localparam int unsigned ButtonW  = 3;
  localparam int unsigned FloorW   = 3;
  localparam int unsigned FloorsN  = 4;
  localparam int unsigned DutyW    = 7;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  localparam logic [TickW-1:0] CloseRst = 16'd1000;
  localparam logic [TickW-1:0] MoveRst  = 16'd6000;
  localparam logic [TickW-1:0] OpenRst  = 16'd1000;
  localparam logic [TickW-1:0] DwellRst = 16'd2000;
  localparam logic [TickW-1:0] WaitRst  = 16'd1000;
  localparam logic [TickW-1:0] LightRst = 16'd400;

  localparam logic [DutyW-1:0] DutyUp      = 7'd80;
  localparam logic [DutyW-1:0] DutyDown    = 7'd60;
  localparam logic [DutyW-1:0] DutyOpening = 7'd60;
  localparam logic [DutyW-1:0] DutyClosing = 7'd50;

  localparam logic [BlinkW-1:0] BlinkStep1 = 10'd250;
  localparam logic [BlinkW-1:0] BlinkStep2 = 10'd500;
  localparam logic [BlinkW-1:0] BlinkStep3 = 10'd750;
  localparam logic [BlinkW-1:0] BlinkEnd   = 10'd1000;

endpackage

`default_nettype wire

>>> rtl/efc_in_if.sv
// Tick request channel: valid/ready handshake with the button event.
`default_nettype none

interface efc_in_if
  import efc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ButtonW-1:0] button;

  modport source (output valid, output button, input ready);
  modport sink   (input valid, input button, output ready);
endinterface

`default_nettype wire

>>> rtl/efc_out_if.sv
// Status request channel: valid/ready handshake with the controller outputs.
`default_nettype none

interface efc_out_if
  import efc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [2:0]         phase;
  logic [FloorW-1:0]  floor_now;
  logic [FloorsN-1:0] target_mask;
  logic               going_up;
  logic               idle_out;
  logic [DutyW-1:0]   motor_duty;
  logic [DutyW-1:0]   door_duty;
  logic [FloorsN-1:0] light_pattern;
  logic               show_floor;

  modport source (output valid, output phase, output floor_now, output target_mask,
                  output going_up, output idle_out, output motor_duty, output door_duty,
                  output light_pattern, output show_floor, input ready);
  modport sink   (input valid, input phase, input floor_now, input target_mask,
                  input going_up, input idle_out, input motor_duty, input door_duty,
                  input light_pattern, input show_floor, output ready);
endinterface

`default_nettype wire

>>> rtl/elevator_floor_controller.sv
// A status request appears in the output register in the cycle after its tick is taken.
// Throughput: one tick request per cycle; the output register frees itself when the sink
//   takes the pending request in the same cycle, so only a stalled output holds the input.
// Reset (rst_ni low, asynchronous): phase idle at floor 1, no targets, heading up,
//   all timers cleared, timing registers back to their defaults, output register empty.
`default_nettype none

module elevator_floor_controller
  import efc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  efc_in_if.sink                in_i,
  efc_out_if.source             out_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  // Timing registers
  logic [TickW-1:0] close_q, move_q, open_q, dwell_q, wait_q, light_step_q;

  // Controller state
  phase_e             phase_q, phase_d;
  logic [FloorsN-1:0] floor_q, floor_d;
  logic [FloorsN-1:0] targets_q, targets_d;
  logic               up_q, up_d;
  logic [TickW-1:0]   phase_cnt_q, phase_cnt_d;
  logic [TickW-1:0]   phase_lim_q, phase_lim_d;
  logic               waiting_q, waiting_d;
  logic [TickW-1:0]   wait_cnt_q, wait_cnt_d;
  logic [FloorsN-1:0] light_q, light_d;
  logic [TickW-1:0]   light_cnt_q, light_cnt_d;
  logic               blink_on_q, blink_on_d;
  logic               blink_ph_q, blink_ph_d;
  logic [BlinkW-1:0]  blink_cnt_q, blink_cnt_d;

  // Output register
  logic               out_valid_q;
  logic [2:0]         o_phase_q, o_phase_d;
  logic [FloorW-1:0]  o_floor_q, o_floor_d;
  logic [FloorsN-1:0] o_targets_q;
  logic               o_up_q;
  logic               o_idle_q, o_idle_d;
  logic [DutyW-1:0]   o_motor_q, o_motor_d;
  logic [DutyW-1:0]   o_door_q, o_door_d;
  logic [FloorsN-1:0] o_light_q, o_light_d;
  logic               o_show_q, o_show_d;

  logic accept;
  logic cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration port: zero-wait writes, reads return the 16-bit register.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      close_q      <= CloseRst;
      move_q       <= MoveRst;
      open_q       <= OpenRst;
      dwell_q      <= DwellRst;
      wait_q       <= WaitRst;
      light_step_q <= LightRst;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[4:2]))
        REG_CLOSE: close_q      <= pwdata[TickW-1:0];
        REG_MOVE:  move_q       <= pwdata[TickW-1:0];
        REG_OPEN:  open_q       <= pwdata[TickW-1:0];
        REG_DWELL: dwell_q      <= pwdata[TickW-1:0];
        REG_WAIT:  wait_q       <= pwdata[TickW-1:0];
        REG_LIGHT: light_step_q <= pwdata[TickW-1:0];
        default: ;  // addresses past the last register are dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[4:2]))
      REG_CLOSE: prdata = {{(DataW-TickW){1'b0}}, close_q};
      REG_MOVE:  prdata = {{(DataW-TickW){1'b0}}, move_q};
      REG_OPEN:  prdata = {{(DataW-TickW){1'b0}}, open_q};
      REG_DWELL: prdata = {{(DataW-TickW){1'b0}}, dwell_q};
      REG_WAIT:  prdata = {{(DataW-TickW){1'b0}}, wait_q};
      REG_LIGHT: prdata = {{(DataW-TickW){1'b0}}, light_step_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: take a tick whenever the output register is empty or drains now.
  // ---------------------------------------------------------------------------
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Next state: one tick, applied in order button, light, phase timer,
  // wait timer, blink. Each step sees what the earlier steps left.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic               btn_ok;
    logic [FloorsN-1:0] btn_bit;
    logic [TickW-1:0]   lc_inc, pc_inc, wc_inc;
    logic [BlinkW-1:0]  bc_inc;

    phase_d     = phase_q;
    floor_d     = floor_q;
    targets_d   = targets_q;
    up_d        = up_q;
    phase_cnt_d = phase_cnt_q;
    phase_lim_d = phase_lim_q;
    waiting_d   = waiting_q;
    wait_cnt_d  = wait_cnt_q;
    light_d     = light_q;
    light_cnt_d = light_cnt_q;
    blink_on_d  = blink_on_q;
    blink_ph_d  = blink_ph_q;
    blink_cnt_d = blink_cnt_q;

    // Floor-1 call while parked at floor 1 means nothing; codes 5..7 are no event.
    btn_ok  = (in_i.button >= 3'd1) && (in_i.button <= 3'd4) &&
              !((in_i.button == 3'd1) && floor_q[0]);
    btn_bit = FloorsN'(1) << (in_i.button[1:0] - 2'd1);

    lc_inc = light_cnt_q + 16'd1;
    pc_inc = phase_cnt_q + 16'd1;
    wc_inc = '0;
    bc_inc = '0;

    if (accept) begin
      // Button: toggle the target and restart the wait.
      if ((phase_q == PH_IDLE || phase_q == PH_DWELL) && btn_ok) begin
        targets_d  = targets_q ^ btn_bit;
        waiting_d  = 1'b1;
        wait_cnt_d = '0;
      end

      // Running light: rotate in the travel direction.
      if (phase_q == PH_MOVING) begin
        if (lc_inc >= light_step_q) begin
          light_cnt_d = '0;
          light_d     = up_q ? {light_q[2:0], light_q[3]} : {light_q[0], light_q[3:1]};
        end else begin
          light_cnt_d = lc_inc;
        end
      end

      // Phase timer: advance the phase when its count runs out.
      if (!waiting_d && phase_q != PH_IDLE) begin
        if (pc_inc >= phase_lim_q) begin
          phase_cnt_d = '0;
          case (phase_q)
            PH_DWELL: begin
              phase_d     = PH_CLOSING;
              phase_lim_d = close_q;
            end
            PH_CLOSING: begin
              phase_d     = PH_MOVING;
              phase_lim_d = move_q;
            end
            PH_MOVING: begin
              phase_d     = PH_OPENING;
              phase_lim_d = open_q;
            end
            PH_OPENING: begin
              // Arrive: step one floor (saturating), clear its call, start the blink.
              if (up_q) begin
                floor_d = floor_q[3] ? floor_q : {floor_q[2:0], 1'b0};
              end else begin
                floor_d = floor_q[0] ? floor_q : {1'b0, floor_q[3:1]};
              end
              targets_d   = targets_d & ~floor_d;
              up_d        = targets_d > floor_d;
              blink_on_d  = 1'b1;
              phase_d     = (targets_d == '0) ? PH_IDLE : PH_DWELL;
              phase_lim_d = dwell_q;
            end
            default: ;
          endcase
        end else begin
          phase_cnt_d = pc_inc;
        end
      end

      // Wait timer: close the door, or go idle when no call is left.
      if (waiting_d) begin
        wc_inc = wait_cnt_d + 16'd1;
        if (wc_inc >= wait_q) begin
          wait_cnt_d = '0;
          waiting_d  = 1'b0;
          if (targets_d == '0) begin
            phase_d = PH_IDLE;
          end else begin
            phase_d     = PH_CLOSING;
            phase_cnt_d = '0;
            phase_lim_d = close_q;
          end
          up_d = targets_d > floor_d;
        end else begin
          wait_cnt_d = wc_inc;
        end
      end

      // Arrival blink: toggle at each of BlinkStep1..3, stop at BlinkEnd.
      if (blink_on_d) begin
        bc_inc      = blink_cnt_d + 10'd1;
        blink_cnt_d = bc_inc;
        if (bc_inc == BlinkEnd) begin
          blink_on_d  = 1'b0;
          blink_cnt_d = '0;
          blink_ph_d  = 1'b0;
        end else if (bc_inc == BlinkStep1 || bc_inc == BlinkStep2 ||
                     bc_inc == BlinkStep3) begin
          blink_ph_d = !blink_ph_d;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output decode from the updated state.
  // ---------------------------------------------------------------------------
  always_comb begin
    o_phase_d = 3'(phase_d);
    o_idle_d  = (phase_d == PH_IDLE) || (phase_d == PH_DWELL);
    o_motor_d = (phase_d == PH_MOVING) ? (up_d ? DutyUp : DutyDown) : '0;
    case (phase_d)
      PH_OPENING: o_door_d = DutyOpening;
      PH_CLOSING: o_door_d = DutyClosing;
      default:    o_door_d = '0;
    endcase
    o_light_d = (phase_d == PH_MOVING) ? light_d : '0;
    o_show_d  = !(blink_on_d && blink_ph_d);
    if (floor_d[3]) begin
      o_floor_d = 3'd4;
    end else if (floor_d[2]) begin
      o_floor_d = 3'd3;
    end else if (floor_d[1]) begin
      o_floor_d = 3'd2;
    end else begin
      o_floor_d = 3'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      floor_q     <= 4'b0001;
      targets_q   <= '0;
      up_q        <= 1'b1;
      phase_cnt_q <= '0;
      phase_lim_q <= CloseRst;
      waiting_q   <= 1'b0;
      wait_cnt_q  <= '0;
      light_q     <= 4'b0001;
      light_cnt_q <= '0;
      blink_on_q  <= 1'b0;
      blink_ph_q  <= 1'b0;
      blink_cnt_q <= '0;
    end else begin
      phase_q     <= phase_d;
      floor_q     <= floor_d;
      targets_q   <= targets_d;
      up_q        <= up_d;
      phase_cnt_q <= phase_cnt_d;
      phase_lim_q <= phase_lim_d;
      waiting_q   <= waiting_d;
      wait_cnt_q  <= wait_cnt_d;
      light_q     <= light_d;
      light_cnt_q <= light_cnt_d;
      blink_on_q  <= blink_on_d;
      blink_ph_q  <= blink_ph_d;
      blink_cnt_q <= blink_cnt_d;
    end
  end

  // Output register: valid flag under reset, payload loads on accept.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      o_phase_q   <= o_phase_d;
      o_floor_q   <= o_floor_d;
      o_targets_q <= targets_d;
      o_up_q      <= up_d;
      o_idle_q    <= o_idle_d;
      o_motor_q   <= o_motor_d;
      o_door_q    <= o_door_d;
      o_light_q   <= o_light_d;
      o_show_q    <= o_show_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.phase         = o_phase_q;
  assign out_o.floor_now     = o_floor_q;
  assign out_o.target_mask   = o_targets_q;
  assign out_o.going_up      = o_up_q;
  assign out_o.idle_out      = o_idle_q;
  assign out_o.motor_duty    = o_motor_q;
  assign out_o.door_duty     = o_door_q;
  assign out_o.light_pattern = o_light_q;
  assign out_o.show_floor    = o_show_q;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the four-floor elevator floor controller.
`timescale 1ns / 100ps

module testbench
  import efc_pkg::*;
();

  // Expected status of the car after one tick, one field per output.
  typedef struct packed {
    logic [2:0]         phase;
    logic [FloorW-1:0]  floor_now;
    logic [FloorsN-1:0] target_mask;
    logic               going_up;
    logic               idle_out;
    logic [DutyW-1:0]   motor_duty;
    logic [DutyW-1:0]   door_duty;
    logic [FloorsN-1:0] light_pattern;
    logic               show_floor;
  } car_status_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  efc_in_if  tick_if ();
  efc_out_if status_if ();

  elevator_floor_controller DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (tick_if),
    .out_o   (status_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock: 2 ns period, starts high.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Car model: a private copy of the controller state and its timing registers.
  // ---------------------------------------------------------------------------
  logic [TickW-1:0]   timing [6];
  phase_e             car_phase    = PH_IDLE;
  logic [FloorsN-1:0] car_floor_oh = 4'b0001;
  logic [FloorsN-1:0] call_mask    = '0;
  logic               heading_up   = 1'b1;
  logic [TickW-1:0]   phase_ticks  = '0;
  logic [TickW-1:0]   phase_span   = CloseRst;
  logic               awaiting     = 1'b0;
  logic [TickW-1:0]   await_ticks  = '0;
  logic [FloorsN-1:0] lamp_oh      = 4'b0001;
  logic [TickW-1:0]   lamp_ticks   = '0;
  logic               blink_on     = 1'b0;
  logic               blink_dark   = 1'b0;
  int                 blink_ticks  = 0;

  car_status_t        awaited_status [$];
  logic [ButtonW-1:0] pending_buttons [$];

  int mismatch_count = 0;
  bit pace_idle      = 1'b0;
  int hold_requests  = 0;
  int holds_started  = 0;
  int hold_left      = 0;
  int gap_left       = 0;
  int stall_left     = 0;

  // Count up one tick; a return of zero means the counter reached its limit and cleared.
  function automatic logic [TickW-1:0] bump_count(input logic [TickW-1:0] count,
                                                  input logic [TickW-1:0] limit);
    logic [TickW:0] nxt;
    nxt = count + 1'b1;
    return (nxt >= limit) ? '0 : nxt[TickW-1:0];
  endfunction

  // Per-item pause for either side; zero in the stretches that run without idling.
  function automatic int draw_pause();
    return pace_idle ? $urandom_range(0, 12) : 0;
  endfunction

  // Apply one tick to the car model and queue the status it must produce.
  task automatic advance_car(input logic [ButtonW-1:0] btn);
    car_status_t s;
    // Take the button only while the doors are open or the car is parked.
    if (car_phase == PH_IDLE || car_phase == PH_DWELL) begin
      if (btn >= 3'd1 && btn <= 3'd4 && !(btn == 3'd1 && car_floor_oh == 4'b0001)) begin
        call_mask   = call_mask ^ (4'b0001 << (btn - 3'd1));
        awaiting    = 1'b1;
        await_ticks = '0;
      end
    end
    // Advance the running light while moving, wrapping at either end.
    if (car_phase == PH_MOVING) begin
      lamp_ticks = bump_count(lamp_ticks, timing[REG_LIGHT]);
      if (lamp_ticks == '0) begin
        if (heading_up) lamp_oh = (lamp_oh != 4'b1000) ? lamp_oh << 1 : 4'b0001;
        else            lamp_oh = (lamp_oh != 4'b0001) ? lamp_oh >> 1 : 4'b1000;
      end
    end
    // Phase timer, frozen while the wait period runs or the car is parked.
    if (!awaiting && car_phase != PH_IDLE) begin
      phase_ticks = bump_count(phase_ticks, phase_span);
      if (phase_ticks == '0) begin
        case (car_phase)
          PH_DWELL: begin
            car_phase  = PH_CLOSING;
            phase_span = timing[REG_CLOSE];
          end
          PH_CLOSING: begin
            car_phase  = PH_MOVING;
            phase_span = timing[REG_MOVE];
          end
          PH_MOVING: begin
            car_phase  = PH_OPENING;
            phase_span = timing[REG_OPEN];
          end
          PH_OPENING: begin
            // Arrive one floor on, saturating at the top and bottom floors.
            if (heading_up) begin
              if (car_floor_oh != 4'b1000) car_floor_oh = car_floor_oh << 1;
            end else begin
              if (car_floor_oh != 4'b0001) car_floor_oh = car_floor_oh >> 1;
            end
            call_mask  = call_mask & ~car_floor_oh;
            heading_up = call_mask > car_floor_oh;
            blink_on   = 1'b1;
            car_phase  = (call_mask == '0) ? PH_IDLE : PH_DWELL;
            phase_span = timing[REG_DWELL];
          end
          default: ;
        endcase
      end
    end
    // Wait period: close the doors if anything is requested, else park.
    if (awaiting) begin
      await_ticks = bump_count(await_ticks, timing[REG_WAIT]);
      if (await_ticks == '0) begin
        awaiting = 1'b0;
        if (call_mask == '0) begin
          car_phase = PH_IDLE;
        end else begin
          car_phase   = PH_CLOSING;
          phase_ticks = '0;
          phase_span  = timing[REG_CLOSE];
        end
        heading_up = call_mask > car_floor_oh;
      end
    end
    // Arrival blink: toggle every step, stop at the end; a new arrival keeps the count.
    if (blink_on) begin
      blink_ticks = blink_ticks + 1;
      if (blink_ticks % int'(BlinkStep1) == 0) begin
        if (blink_ticks >= int'(BlinkEnd)) begin
          blink_on    = 1'b0;
          blink_ticks = 0;
          blink_dark  = 1'b0;
        end else begin
          blink_dark = !blink_dark;
        end
      end
    end

    s.phase       = car_phase;
    s.floor_now   = car_floor_oh[3] ? 3'd4 : car_floor_oh[2] ? 3'd3 :
                    car_floor_oh[1] ? 3'd2 : 3'd1;
    s.target_mask = call_mask;
    s.going_up    = heading_up;
    s.idle_out    = (car_phase == PH_IDLE || car_phase == PH_DWELL);
    s.motor_duty  = (car_phase == PH_MOVING) ? (heading_up ? DutyUp : DutyDown) : '0;
    s.door_duty   = (car_phase == PH_OPENING) ? DutyOpening :
                    (car_phase == PH_CLOSING) ? DutyClosing : '0;
    s.light_pattern = (car_phase == PH_MOVING) ? lamp_oh : '0;
    s.show_floor  = !(blink_on && blink_dark);
    awaited_status.push_back(s);
  endtask

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      if (mismatch_count < 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tick driver: feed queued button events, predict on each accepted request.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_if.valid  <= 1'b0;
      tick_if.button <= '0;
      gap_left = 0;
    end else begin
      if (tick_if.valid && tick_if.ready) advance_car(tick_if.button);
      // Hold the current request until taken, then pause or load the next one.
      if (!tick_if.valid || tick_if.ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          tick_if.valid <= 1'b0;
        end else if (pending_buttons.size() != 0) begin
          tick_if.valid  <= 1'b1;
          tick_if.button <= pending_buttons.pop_front();
          gap_left = draw_pause();
        end else begin
          tick_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_started != hold_requests) begin
      holds_started <= holds_started + 1;
      hold_left     <= 100;
    end
  end

  // ---------------------------------------------------------------------------
  // Status monitor: check each accepted request against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_if.ready <= 1'b0;
      stall_left = 0;
    end else begin : sink_side
      car_status_t want;
      if (status_if.valid && status_if.ready) begin
        if (awaited_status.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: status request with no tick outstanding", $realtime);
          mismatch_count++;
        end else begin
          want = awaited_status.pop_front();
          compare_field("phase",         want.phase,         status_if.phase);
          compare_field("floor_now",     want.floor_now,     status_if.floor_now);
          compare_field("target_mask",   want.target_mask,   status_if.target_mask);
          compare_field("going_up",      want.going_up,      status_if.going_up);
          compare_field("idle_out",      want.idle_out,      status_if.idle_out);
          compare_field("motor_duty",    want.motor_duty,    status_if.motor_duty);
          compare_field("door_duty",     want.door_duty,     status_if.door_duty);
          compare_field("light_pattern", want.light_pattern, status_if.light_pattern);
          compare_field("show_floor",    want.show_floor,    status_if.show_floor);
        end
        stall_left = draw_pause();
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
      end
      status_if.ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Write one timing register over the APB port and mirror it in the model.
  task automatic write_timing(input cfg_reg_e idx, input logic [TickW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    timing[idx] = value;
  endtask

  task automatic set_timing(input int close_t, input int move_t, input int open_t,
                            input int dwell_t, input int wait_t, input int light_t);
    write_timing(REG_CLOSE, close_t[TickW-1:0]);
    write_timing(REG_MOVE,  move_t[TickW-1:0]);
    write_timing(REG_OPEN,  open_t[TickW-1:0]);
    write_timing(REG_DWELL, dwell_t[TickW-1:0]);
    write_timing(REG_WAIT,  wait_t[TickW-1:0]);
    write_timing(REG_LIGHT, light_t[TickW-1:0]);
  endtask

  // Block until every queued tick went in and every status came back.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_buttons.size() != 0 || tick_if.valid || awaited_status.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // Mostly plain ticks so the phases run, often floor buttons, rarely unused codes.
  function automatic logic [ButtonW-1:0] draw_button();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return '0;
    if (r < 93) return ButtonW'($urandom_range(1, 4));
    return ButtonW'($urandom_range(5, 7));
  endfunction

  // Kill a hung run.
  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [ButtonW-1:0] at_reset [10];
    int hi;
    at_reset = '{3'd0, 3'd1, 3'd5, 3'd6, 3'd7, 3'd2, 3'd3, 3'd3, 3'd4, 3'd0};
    tick_if.valid   = 1'b0;
    tick_if.button  = '0;
    status_if.ready = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    timing[REG_CLOSE] = CloseRst;
    timing[REG_MOVE]  = MoveRst;
    timing[REG_OPEN]  = OpenRst;
    timing[REG_DWELL] = DwellRst;
    timing[REG_WAIT]  = WaitRst;
    timing[REG_LIGHT] = LightRst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset timing: floor 1 at floor 1 ignored, unused codes ignored, a button toggled off.
    foreach (at_reset[i]) pending_buttons.push_back(at_reset[i]);
    settle();

    // Shortest timing: every phase lasts one tick; press a button mid-trip to see it dropped.
    set_timing(1, 1, 1, 1, 1, 1);
    repeat (6) pending_buttons.push_back(3'd0);
    pending_buttons.push_back(3'd3);
    repeat (12) pending_buttons.push_back(3'd0);
    settle();

    // Press and cancel the same floor inside the wait so the car parks empty.
    set_timing(2, 2, 2, 2, 3, 2);
    pending_buttons.push_back(3'd2);
    pending_buttons.push_back(3'd2);
    repeat (4) pending_buttons.push_back(3'd0);
    settle();

    // Random phases with short timing so trips, arrivals and blinks happen often.
    for (int ph = 0; ph < 7; ph++) begin
      hi = (ph == 4) ? 40 : 5;
      set_timing($urandom_range(1, hi), $urandom_range(1, hi), $urandom_range(1, hi),
                 $urandom_range(1, hi), $urandom_range(1, hi), $urandom_range(1, 3));
      pace_idle = (ph % 3 != 1);
      // Back-pressure: stall the status side while ticks keep coming.
      if (ph == 2) begin
        pace_idle = 1'b0;
        hold_requests++;
      end
      repeat (112) pending_buttons.push_back(draw_button());
      settle();
    end

    // Longest timing last, since a phase started here never ends within the run.
    pace_idle = 1'b1;
    set_timing(65535, 65535, 65535, 65535, 65535, 65535);
    repeat (30) pending_buttons.push_back(draw_button());
    settle();

    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && awaited_status.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
